@@ sv/amg_pkg.sv @@
// shared widths, opcodes and status codes of the adjacency matrix graph table
package amg_pkg;

  localparam int VERTICES_DEF = 16;

  localparam int OPCODE_W = 3;
  localparam int VID_W    = 4;
  localparam int WEIGHT_W = 16;
  localparam int STATUS_W = 3;

  // slave tdata: opcode, first_vertex, second_vertex, edge_weight
  localparam int S_FIELDS_W = OPCODE_W + 2 * VID_W + WEIGHT_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  // master tdata: status, edge_value
  localparam int M_FIELDS_W = STATUS_W + WEIGHT_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [OPCODE_W-1:0] OP_ADD_VERTEX   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD_UNIT     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD_WEIGHTED = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DEL_VERTEX   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DEL_EDGE     = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR        = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_READ_EDGE    = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INCOMING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOEDGE   = 3'd4;

endpackage

@@ sv/amg_ram.sv @@
// matrix cell memory: one write port, one registered read port
module amg_ram import amg_pkg::*; #(
  parameter int AW = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [WEIGHT_W-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [WEIGHT_W-1:0] rdata
);

  logic [WEIGHT_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/adjacency_matrix_graph_table_top.sv @@
// adjacency matrix graph table: presence bits in flops, edge weights in one memory
// one operation at a time; add vertex, vertex errors and unused codes go straight to S_FIN;
// add edge writes the cell in S_WR1 and, if undirected, its mirror in S_WR2; read edge and
// delete edge read the cell in S_RD and S_CHK first; delete vertex scans its column (one
// column read per cycle) and clear zeroes the matrix (one cell zeroed per cycle);
// after reset the matrix is swept with s_tready low, presence bits and mode clear at once
module adjacency_matrix_graph_table_top import amg_pkg::*; #(
  parameter int VERTICES = VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,  // directed_mode
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,      // opcode, first_vertex, second_vertex, edge_weight
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata       // status, edge_value
);

  localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int AW = 2 * VW;
  localparam logic [VW-1:0] LAST_V = VW'(VERTICES - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WR1      = 4'd1;
  localparam logic [3:0] S_WR2      = 4'd2;
  localparam logic [3:0] S_RD       = 4'd3;
  localparam logic [3:0] S_CHK      = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_SCAN_END = 4'd6;
  localparam logic [3:0] S_CLR      = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0]          state;
  logic                directed_mode;
  logic [VERTICES-1:0] vertex_present;
  logic [OPCODE_W-1:0] op_r;
  logic [VW-1:0]       a_r;
  logic [VW-1:0]       b_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [STATUS_W-1:0] status_r;
  logic [WEIGHT_W-1:0] value_r;
  logic [VW-1:0]       cnt;
  logic [VW-1:0]       col;
  logic                hit;
  logic                rd_pend;
  logic                boot;

  logic [OPCODE_W-1:0] in_op;
  logic [VID_W-1:0]    in_first;
  logic [VID_W-1:0]    in_second;
  logic [WEIGHT_W-1:0] in_weight;
  logic [VW-1:0]       a_idx;
  logic [VW-1:0]       b_idx;
  logic                a_in_rng;
  logic                b_in_rng;
  logic                a_pres;
  logic                b_pres;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [WEIGHT_W-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [WEIGHT_W-1:0] mem_rdata;

  assign in_op     = s_tdata[OPCODE_W-1:0];
  assign in_first  = s_tdata[OPCODE_W +: VID_W];
  assign in_second = s_tdata[OPCODE_W + VID_W +: VID_W];
  assign in_weight = s_tdata[OPCODE_W + 2 * VID_W +: WEIGHT_W];

  assign a_in_rng = int'(in_first) < VERTICES;
  assign b_in_rng = int'(in_second) < VERTICES;
  assign a_idx    = VW'(in_first);
  assign b_idx    = VW'(in_second);
  assign a_pres   = a_in_rng && vertex_present[a_idx];
  assign b_pres   = b_in_rng && vertex_present[b_idx];

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      directed_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      directed_mode <= cfg_wr_data;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {a_r, b_r};
    mem_wdata = w_r;
    mem_raddr = {a_r, b_r};
    case (state)
      S_WR1: begin
        mem_we = 1'b1;
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = {b_r, a_r};
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = {cnt, col};
        mem_wdata = '0;
      end
      S_SCAN: begin
        mem_raddr = {cnt, a_r};
      end
      default: begin
      end
    endcase
  end

  amg_ram #(
    .AW(AW)
  ) u_cells (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      boot           <= 1'b1;
      cnt            <= '0;
      col            <= '0;
      hit            <= 1'b0;
      rd_pend        <= 1'b0;
      vertex_present <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r     <= in_op;
            a_r      <= a_idx;
            b_r      <= b_idx;
            w_r      <= in_weight;
            status_r <= ST_OK;
            value_r  <= '0;
            hit      <= 1'b0;
            cnt      <= '0;
            col      <= '0;
            state    <= S_FIN;
            case (in_op)
              OP_ADD_VERTEX: begin
                if (!a_in_rng) begin
                  status_r <= ST_MISSING;
                end else if (vertex_present[a_idx]) begin
                  status_r <= ST_PRESENT;
                end else begin
                  vertex_present[a_idx] <= 1'b1;
                end
              end
              OP_ADD_UNIT, OP_ADD_WEIGHTED: begin
                if (!(a_pres && b_pres)) begin
                  status_r <= ST_MISSING;
                end else begin
                  if (in_op == OP_ADD_UNIT) begin
                    w_r <= WEIGHT_W'(1);
                  end
                  state <= S_WR1;
                end
              end
              OP_DEL_VERTEX: begin
                if (!a_pres) begin
                  status_r <= ST_MISSING;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_DEL_EDGE: begin
                w_r <= '0;
                if (!(a_pres && b_pres)) begin
                  status_r <= ST_MISSING;
                end else begin
                  state <= S_RD;
                end
              end
              OP_CLEAR: begin
                vertex_present <= '0;
                boot           <= 1'b0;
                state          <= S_CLR;
              end
              OP_READ_EDGE: begin
                if (!(a_in_rng && b_in_rng)) begin
                  status_r <= ST_MISSING;
                end else begin
                  state <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WR1: begin
          state <= directed_mode ? S_FIN : S_WR2;
        end
        S_WR2: begin
          state <= S_FIN;
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (op_r == OP_READ_EDGE) begin
            value_r <= mem_rdata;
            state   <= S_FIN;
          end else if (mem_rdata == '0) begin
            status_r <= ST_NOEDGE;
            state    <= S_FIN;
          end else begin
            state <= S_WR1;
          end
        end
        S_SCAN: begin
          // data of the previous column read arrives while the next is issued
          rd_pend <= 1'b1;
          if (rd_pend && mem_rdata != '0) begin
            hit <= 1'b1;
          end
          if (cnt == LAST_V) begin
            state <= S_SCAN_END;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SCAN_END: begin
          rd_pend <= 1'b0;
          if (hit || mem_rdata != '0) begin
            status_r <= ST_INCOMING;
          end else begin
            vertex_present[a_r] <= 1'b0;
          end
          state <= S_FIN;
        end
        S_CLR: begin
          if (col == LAST_V) begin
            col <= '0;
            if (cnt == LAST_V) begin
              state <= boot ? S_IDLE : S_FIN;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_DATA_W'({value_r, status_r});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer taken while an operation is in progress");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("matrix written while idle");

  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_tready)
    else $error("input taken before the matrix sweep after reset");

  a_scan_data: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_END |-> rd_pend)
    else $error("column scan ended without a pending read");

endmodule
